>>> design/go_to_point_steering_assert.svh
// Assertion macros for the checker file of the steering block.
`ifndef GO_TO_POINT_STEERING_ASSERT_SVH
`define GO_TO_POINT_STEERING_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define GTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define GTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/gts_pkg.sv
// Shared types, constants and tables for the go-to-point steering block.
package gts_pkg;

  // CORDIC sizing.
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 5;
  localparam int CW           = 36;

  // Angles are radians times 2^30.
  localparam logic signed [CW-1:0] ANG_PI     = CW'(64'd3373259426);
  localparam logic [29:0]          INV_GAIN   = 30'd652032874;

  // Error path and distance widths.
  localparam int D_W    = 38;
  localparam int ERR_W  = D_W - 17;
  localparam int MAG_W  = 35;
  localparam int DIST_W = 29;
  localparam logic signed [D_W-1:0] D_PI     = D_W'(64'd3373259426);
  localparam logic signed [D_W-1:0] D_TWO_PI = D_W'(64'd6746518852);

  // Divider sizing: quotients stay below 2^15 inside a slow-down zone.
  localparam int DIV_STEPS  = 15;
  localparam int DIV_STEP_W = 4;
  localparam int REM_W      = 38;
  localparam int DEN_W      = 23;

  // Stream payload widths.
  localparam int IN_W  = 128;
  localparam int OUT_W = 56;

  // Pipeline stage positions.
  localparam int ST_PRE = 0;
  localparam int ST_C0  = 1;
  localparam int ST_M1  = CORDIC_STEPS + 1;
  localparam int ST_M2  = ST_M1 + 1;
  localparam int ST_M3  = ST_M1 + 2;
  localparam int ST_M4  = ST_M1 + 3;
  localparam int ST_M5  = ST_M1 + 4;
  localparam int ST_M6  = ST_M1 + 5;
  localparam int ST_D0  = ST_M6 + 1;
  localparam int ST_OUT = ST_D0 + DIV_STEPS;
  localparam int NST    = ST_OUT + 1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DIST_TOL,
    CFG_ANGLE_TOL,
    CFG_SLOW_DIST,
    CFG_SLOW_ANGLE,
    CFG_MAX_FWD,
    CFG_MIN_FWD,
    CFG_MAX_TURN,
    CFG_MIN_TURN
  } cfg_idx_t;

  // One CORDIC vector in flight.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 zero;
  } cordic_t;

  // One restoring division in flight.
  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [DEN_W-1:0]     den;
    logic [DIV_STEPS-1:0] q;
  } div_t;

  // Flags and error that ride along the divider chain.
  typedef struct packed {
    logic        at_target;
    logic        facing;
    logic        tzone;
    logic        fzone;
    logic        neg;
    logic [15:0] err;
  } side_t;

  // Arctangent of 2^-i scaled by 2^30, truncated.
  function automatic logic signed [CW-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] a;
    case (i)
      5'd0:    a = CW'(32'h3243F6A8);
      5'd1:    a = CW'(32'h1DAC6705);
      5'd2:    a = CW'(32'h0FADBAFC);
      5'd3:    a = CW'(32'h07F56EA6);
      5'd4:    a = CW'(32'h03FEAB76);
      5'd5:    a = CW'(32'h01FFD55B);
      5'd6:    a = CW'(32'h00FFFAAA);
      5'd7:    a = CW'(32'h007FFF55);
      5'd8:    a = CW'(32'h003FFFEA);
      5'd9:    a = CW'(32'h001FFFFD);
      5'd10:   a = CW'(32'h000FFFFF);
      5'd11:   a = CW'(32'h0007FFFF);
      5'd12:   a = CW'(32'h0003FFFF);
      5'd13:   a = CW'(32'h0001FFFF);
      5'd14:   a = CW'(32'h0000FFFF);
      5'd15:   a = CW'(32'h00007FFF);
      5'd16:   a = CW'(32'h00003FFF);
      5'd17:   a = CW'(32'h00001FFF);
      5'd18:   a = CW'(32'h00000FFF);
      5'd19:   a = CW'(32'h000007FF);
      5'd20:   a = CW'(32'h000003FF);
      5'd21:   a = CW'(32'h000001FF);
      5'd22:   a = CW'(32'h000000FF);
      5'd23:   a = CW'(32'h0000007F);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> design/gts_cordic_cell.sv
// One CORDIC vectoring cell: rotates the bearing and heading vectors by one step.
module gts_cordic_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gts_pkg::STEP_W-1:0]  step,
  input  gts_pkg::cordic_t            in_b,
  input  gts_pkg::cordic_t            in_h,
  output gts_pkg::cordic_t            out_b,
  output gts_pkg::cordic_t            out_h
);
  import gts_pkg::*;

  // Drive y toward zero and accumulate the rotation angle.
  function automatic cordic_t rotate(input cordic_t v, input logic [STEP_W-1:0] i);
    cordic_t r;
    logic signed [CW-1:0] xv;
    logic signed [CW-1:0] yv;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] a;
    xv = v.x;
    yv = v.y;
    xs = xv >>> i;
    ys = yv >>> i;
    a  = atan_lut(i);
    r.zero = v.zero;
    if (!yv[CW-1]) begin
      r.x = xv + ys;
      r.y = yv - xs;
      r.z = v.z + a;
    end else begin
      r.x = xv - ys;
      r.y = yv + xs;
      r.z = v.z - a;
    end
    return r;
  endfunction

  // Hand the rotated vectors to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      out_b <= rotate(in_b, step);
      out_h <= rotate(in_h, step);
    end
  end

endmodule

>>> design/gts_div_cell.sv
// One restoring-division cell: settles one quotient bit of both speed divisions.
module gts_div_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic [gts_pkg::DIV_STEP_W-1:0]  step,
  input  gts_pkg::div_t                   in_t,
  input  gts_pkg::div_t                   in_f,
  output gts_pkg::div_t                   out_t,
  output gts_pkg::div_t                   out_f
);
  import gts_pkg::*;

  // Subtract the shifted divisor when it fits and set the quotient bit.
  function automatic div_t settle(input div_t v, input logic [DIV_STEP_W-1:0] k);
    div_t r;
    logic [REM_W-1:0] sh;
    sh = REM_W'(v.den) << k;
    r  = v;
    if (v.rem >= sh) begin
      r.rem = v.rem - sh;
      r.q   = v.q | (DIV_STEPS'(1) << k);
    end
    return r;
  endfunction

  // Pass the partial results to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      out_t <= settle(in_t, step);
      out_f <= settle(in_f, step);
    end
  end

endmodule

>>> design/go_to_point_steering.sv
// A transaction passes pre-rotation, 16 CORDIC cells, M1 to M6, 15 divider cells, output.
// The pipeline takes one transaction per cycle while the output is not stalled.
// Every stage holds its own valid bit, so bubbles close up while the output is stalled.
// Reset (rst, synchronous, active high) empties the pipeline and loads register defaults.
// Configuration registers are read live by the stages; the user must write them
// only while idle, unenforced by the block. Top level of the go-to-point steering block.
module go_to_point_steering (
  input  logic                       clk,
  input  logic                       rst,
  // pose_x, pose_y, orient_z, orient_w, target_x, target_y (lowest bit up)
  input  logic [gts_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // at_target, facing_target, heading_error, turn_rate, forward_speed, zero fill
  output logic [gts_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_addr,
  input  logic [22:0]                cfg_data
);
  import gts_pkg::*;

  // Configuration registers.
  logic [22:0] dist_tol;
  logic [14:0] ang_tol;
  logic [22:0] slow_dist;
  logic [14:0] slow_ang;
  logic [14:0] max_forward_speed;
  logic [14:0] min_forward_speed;
  logic [14:0] max_turn_rate;
  logic [14:0] min_turn_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_tol           <= 23'd3277;
      ang_tol            <= 15'd410;
      slow_dist          <= 23'd32768;
      slow_ang           <= 15'd4096;
      max_forward_speed  <= 15'd1229;
      min_forward_speed  <= 15'd205;
      max_turn_rate      <= 15'd4096;
      min_turn_rate      <= 15'd410;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_DIST_TOL:   dist_tol           <= cfg_data;
        CFG_ANGLE_TOL:  ang_tol            <= cfg_data[14:0];
        CFG_SLOW_DIST:  slow_dist          <= cfg_data;
        CFG_SLOW_ANGLE: slow_ang           <= cfg_data[14:0];
        CFG_MAX_FWD:    max_forward_speed  <= cfg_data[14:0];
        CFG_MIN_FWD:    min_forward_speed  <= cfg_data[14:0];
        CFG_MAX_TURN:   max_turn_rate      <= cfg_data[14:0];
        CFG_MIN_TURN:   min_turn_rate      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the backward enable chain.
  logic [NST-1:0] vld;
  logic [NST:0]   adv;

  always_comb begin
    adv[NST] = m_axis_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[ST_OUT];

  // Input unpacking and position difference.
  logic signed [23:0] pose_x, pose_y, target_x, target_y;
  logic signed [15:0] orient_z, orient_w;
  logic signed [24:0] dx, dy;

  assign pose_x   = s_axis_tdata[23:0];
  assign pose_y   = s_axis_tdata[47:24];
  assign orient_z = s_axis_tdata[63:48];
  assign orient_w = s_axis_tdata[79:64];
  assign target_x = s_axis_tdata[103:80];
  assign target_y = s_axis_tdata[127:104];
  assign dx = 25'(target_x) - 25'(pose_x);
  assign dy = 25'(target_y) - 25'(pose_y);

  // Fold the left half-plane onto the right by a rotation of pi.
  function automatic cordic_t prerot(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y);
    cordic_t v;
    v.zero = (x == '0) && (y == '0);
    if (x[CW-1]) begin
      v.z = y[CW-1] ? -ANG_PI : ANG_PI;
      v.x = -x;
      v.y = -y;
    end else begin
      v.z = '0;
      v.x = x;
      v.y = y;
    end
    return v;
  endfunction

  cordic_t cb [CORDIC_STEPS+1];
  cordic_t ch [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv[ST_PRE]) begin
      cb[0] <= prerot({{(CW-31){dx[24]}}, dx, 6'b0}, {{(CW-31){dy[24]}}, dy, 6'b0});
      ch[0] <= prerot({{(CW-32){orient_w[15]}}, orient_w, 16'b0},
                      {{(CW-32){orient_z[15]}}, orient_z, 16'b0});
    end
  end

  // Chain of CORDIC cells.
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    gts_cordic_cell u_cell (
      .clk   (clk),
      .en    (adv[ST_C0+g]),
      .step  (STEP_W'(g)),
      .in_b  (cb[g]),
      .in_h  (ch[g]),
      .out_b (cb[g+1]),
      .out_h (ch[g+1])
    );
  end

  // Stage M1: partial products of the gain correction and the raw heading error.
  logic signed [CW-1:0] ang_b, ang_h;
  logic [MAG_W-1:0]     mag;
  logic [46:0]          pp_lo;
  logic [47:0]          pp_hi;
  logic signed [D_W-1:0] m1_d;

  assign ang_b = cb[CORDIC_STEPS].zero ? '0 : cb[CORDIC_STEPS].z;
  assign ang_h = ch[CORDIC_STEPS].zero ? '0 : ch[CORDIC_STEPS].z;
  assign mag   = (cb[CORDIC_STEPS].zero || cb[CORDIC_STEPS].x[CW-1]) ? '0
                                                                     : cb[CORDIC_STEPS].x[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (adv[ST_M1]) begin
      pp_lo <= mag[16:0] * INV_GAIN;
      pp_hi <= mag[MAG_W-1:17] * INV_GAIN;
      m1_d  <= D_W'(ang_b) - (D_W'(ang_h) <<< 1);
    end
  end

  // Stage M2: distance rounding and the first reduction by 2*pi.
  logic [65:0]           dsum;
  logic [DIST_W-1:0]     m2_dist;
  logic signed [D_W-1:0] m2_d;

  assign dsum = {1'b0, pp_hi, 17'b0} + 66'(pp_lo) + (66'd1 << 35);

  always_ff @(posedge clk) begin
    if (adv[ST_M2]) begin
      m2_dist <= dsum[64:36];
      if (m1_d >= D_TWO_PI) begin
        m2_d <= m1_d - D_TWO_PI;
      end else if (m1_d <= -D_TWO_PI) begin
        m2_d <= m1_d + D_TWO_PI;
      end else begin
        m2_d <= m1_d;
      end
    end
  end

  // Stage M3: wrap into the range from -pi to pi.
  logic [DIST_W-1:0]     m3_dist;
  logic signed [D_W-1:0] m3_d;

  always_ff @(posedge clk) begin
    if (adv[ST_M3]) begin
      m3_dist <= m2_dist;
      if (m2_d < -D_PI) begin
        m3_d <= m2_d + D_TWO_PI;
      end else if (m2_d > D_PI) begin
        m3_d <= m2_d - D_TWO_PI;
      end else begin
        m3_d <= m2_d;
      end
    end
  end

  // Stage M4: round the error to Q3.13 and test the distance thresholds.
  logic signed [D_W-1:0]   rnd_d;
  logic signed [ERR_W-1:0] m4_err;
  logic [DIST_W-1:0]       m4_dist;
  logic                    m4_at, m4_fzone;

  assign rnd_d = m3_d + D_W'(1 << 16);

  always_ff @(posedge clk) begin
    if (adv[ST_M4]) begin
      m4_err   <= ERR_W'(rnd_d >>> 17);
      m4_dist  <= m3_dist;
      m4_at    <= m3_dist <= DIST_W'(dist_tol);
      m4_fzone <= (slow_dist != '0) && (m3_dist <= DIST_W'(slow_dist));
    end
  end

  // Stage M5: magnitude of the error.
  logic [ERR_W-1:0]  m5_abs;
  logic [15:0]       m5_err;
  logic              m5_neg, m5_at, m5_fzone;
  logic [DIST_W-1:0] m5_dist;

  always_ff @(posedge clk) begin
    if (adv[ST_M5]) begin
      m5_abs   <= m4_err[ERR_W-1] ? ERR_W'(-m4_err) : ERR_W'(m4_err);
      m5_err   <= m4_err[15:0];
      m5_neg   <= m4_err[ERR_W-1];
      m5_at    <= m4_at;
      m5_fzone <= m4_fzone;
      m5_dist  <= m4_dist;
    end
  end

  // Stage M6: angle thresholds and the proportional numerators.
  div_t  dt [DIV_STEPS+1];
  div_t  df [DIV_STEPS+1];
  side_t sd [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv[ST_M6]) begin
      dt[0].rem <= REM_W'(m5_abs[14:0]) * REM_W'(max_turn_rate);
      dt[0].den <= DEN_W'(slow_ang);
      dt[0].q   <= '0;
      df[0].rem <= REM_W'(m5_dist[22:0]) * REM_W'(max_forward_speed);
      df[0].den <= slow_dist;
      df[0].q   <= '0;
      sd[0].at_target <= m5_at;
      sd[0].facing    <= m5_abs <= ERR_W'(ang_tol);
      sd[0].tzone     <= (slow_ang != '0) && (m5_abs <= ERR_W'(slow_ang));
      sd[0].fzone     <= m5_fzone;
      sd[0].neg       <= m5_neg;
      sd[0].err       <= m5_err;
    end
  end

  // Chain of divider cells, with the flags riding alongside.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    gts_div_cell u_cell (
      .clk   (clk),
      .en    (adv[ST_D0+j]),
      .step  (DIV_STEP_W'(DIV_STEPS - 1 - j)),
      .in_t  (dt[j]),
      .in_f  (df[j]),
      .out_t (dt[j+1]),
      .out_f (df[j+1])
    );

    always_ff @(posedge clk) begin
      if (adv[ST_D0+j]) begin
        sd[j+1] <= sd[j];
      end
    end
  end

  // Output stage: floors, maxima and the sign of the turn command.
  side_t       fin;
  logic [14:0] q_turn, q_fwd, turn_mag, fwd;
  logic [15:0] turn;

  assign fin    = sd[DIV_STEPS];
  assign q_turn = dt[DIV_STEPS].q;
  assign q_fwd  = df[DIV_STEPS].q;

  always_comb begin
    if (fin.tzone) begin
      turn_mag = (q_turn > min_turn_rate) ? q_turn : min_turn_rate;
    end else begin
      turn_mag = max_turn_rate;
    end
    if (fin.fzone) begin
      fwd = (q_fwd > min_forward_speed) ? q_fwd : min_forward_speed;
    end else begin
      fwd = max_forward_speed;
    end
    turn = fin.neg ? -{1'b0, turn_mag} : {1'b0, turn_mag};
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      m_axis_tdata <= {7'b0, fwd, turn, fin.err, fin.facing, fin.at_target};
    end
  end

endmodule

>>> design/go_to_point_steering_chk.sv
// Port-level checker for the go-to-point steering block, bound to the top level.
module go_to_point_steering_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tready,
  input logic [gts_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready
);
  `include "go_to_point_steering_assert.svh"

  // Reset leaves the pipeline empty.
  `GTS_ASSERT_IMP(a_empty_after_reset, $past(rst), !m_axis_tvalid, "result after reset")

  // With nothing at the output, no stage can block the input.
  `GTS_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input blocked while empty")

  // A stalled result stays put.
  `GTS_ASSERT_NXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind go_to_point_steering go_to_point_steering_chk u_chk (.*);

>>> tb/sv/tb_go_to_point_steering.sv
// Self-checking testbench for the go-to-point steering block.
`timescale 1ns / 1ps

module tb_go_to_point_steering;
  import gts_pkg::*;

  localparam int  DRAIN_CYCLES = 45;
  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  RANDOM_ITEMS = 1584;
  localparam int  STEPS        = 16;
  localparam longint RAD_PI     = 64'sd3373259426;
  localparam longint RAD_TWO_PI = 64'sd6746518852;
  localparam longint unsigned CORDIC_GAIN_INV = 64'd652032874;

  // One pose-and-target request.
  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
  } pose_req_t;

  // One steering command.
  typedef struct packed {
    logic               at_target;
    logic               facing;
    logic signed [15:0] heading_err;
    logic signed [15:0] turn;
    logic [14:0]        fwd;
  } steer_cmd_t;

  logic               clk;
  logic               rst;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic               cfg_we;
  logic [2:0]         cfg_addr;
  logic [22:0]        cfg_data;

  longint unsigned    cfg_reg [8];
  steer_cmd_t         pending_cmds [$];
  longint             atan_rom [STEPS];
  int                 errors;
  int                 sent_count;
  int                 checked_count;
  int                 setting_count;
  int                 cycles;
  bit                 no_idle;
  int                 ready_hold;

  go_to_point_steering dut (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("go_to_point_steering verification failed");
      $finish;
    end
  end

  // CORDIC vectoring: angle of (x, y) in radians times 2^30 and raw magnitude.
  function automatic void cordic_vector(input longint xi, input longint yi,
                                        output longint ang, output longint mag);
    longint x, y, z, nx, ny;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    // Left half plane is rotated by pi first.
    if (x < 0) begin
      z = (y >= 0) ? RAD_PI : -RAD_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + atan_rom[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - atan_rom[i];
      end
      x = nx;
      y = ny;
    end
    ang = z;
    mag = (x < 0) ? 0 : x;
  endfunction

  // Steering command for one request under the current register values.
  function automatic steer_cmd_t predict_steering(input pose_req_t r);
    steer_cmd_t      c;
    longint          bearing, half_head, mag, unused_mag, d, err, abs_err, turn;
    longint unsigned goal_dist, fwd, turn_mag, p;
    cordic_vector((longint'(r.tx) - longint'(r.px)) * 64,
                  (longint'(r.ty) - longint'(r.py)) * 64, bearing, mag);
    cordic_vector(longint'(r.qw) * 65536, longint'(r.qz) * 65536, half_head, unused_mag);
    goal_dist = (longint'(mag) * CORDIC_GAIN_INV + (64'd1 << 35)) >> 36;

    // Truncating reduction modulo 2*pi, then wrap into [-pi, pi].
    d = bearing - 2 * half_head;
    if (d >= RAD_TWO_PI) d = d - RAD_TWO_PI;
    else if (d <= -RAD_TWO_PI) d = d + RAD_TWO_PI;
    if (d < 0 && -2 * d > RAD_TWO_PI) d = d + RAD_TWO_PI;
    else if (d >= 0 && 2 * d > RAD_TWO_PI) d = d - RAD_TWO_PI;
    err = (d + (64'sd1 <<< 16)) >>> 17;
    abs_err = (err < 0) ? -err : err;

    // Turn rate: proportional inside the slow-down angle, held up by the floor.
    turn_mag = cfg_reg[CFG_MAX_TURN];
    if (cfg_reg[CFG_SLOW_ANGLE] != 0 && abs_err <= longint'(cfg_reg[CFG_SLOW_ANGLE])) begin
      p = longint'(abs_err) * cfg_reg[CFG_MAX_TURN] / cfg_reg[CFG_SLOW_ANGLE];
      turn_mag = (p > cfg_reg[CFG_MIN_TURN]) ? p : cfg_reg[CFG_MIN_TURN];
    end
    turn = (err < 0) ? -longint'(turn_mag) : longint'(turn_mag);

    // Forward speed: same shape over distance.
    fwd = cfg_reg[CFG_MAX_FWD];
    if (cfg_reg[CFG_SLOW_DIST] != 0 && goal_dist <= cfg_reg[CFG_SLOW_DIST]) begin
      p = goal_dist * cfg_reg[CFG_MAX_FWD] / cfg_reg[CFG_SLOW_DIST];
      fwd = (p > cfg_reg[CFG_MIN_FWD]) ? p : cfg_reg[CFG_MIN_FWD];
    end

    c.at_target   = (goal_dist <= cfg_reg[CFG_DIST_TOL]);
    c.facing      = (abs_err <= longint'(cfg_reg[CFG_ANGLE_TOL]));
    c.heading_err = err[15:0];
    c.turn        = turn[15:0];
    c.fwd         = fwd[14:0];
    return c;
  endfunction

  // Random idle length: mostly none or short, sometimes long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Output side back-pressure.
  always @(posedge clk) begin
    if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
      ready_hold    <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(0, 3);
    end
  end

  // Compare each output transaction with the oldest pending command.
  always @(posedge clk) begin
    steer_cmd_t exp_cmd, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.at_target   = m_axis_tdata[0];
      got.facing      = m_axis_tdata[1];
      got.heading_err = m_axis_tdata[17:2];
      got.turn        = m_axis_tdata[33:18];
      got.fwd         = m_axis_tdata[48:34];
      if (pending_cmds.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
      end else begin
        exp_cmd = pending_cmds.pop_front();
        checked_count = checked_count + 1;
        if (got.at_target !== exp_cmd.at_target) begin
          errors = errors + 1;
          $display("%0t: at_target expected %0d actual %0d",
                   $time, exp_cmd.at_target, got.at_target);
        end
        if (got.facing !== exp_cmd.facing) begin
          errors = errors + 1;
          $display("%0t: facing_target expected %0d actual %0d",
                   $time, exp_cmd.facing, got.facing);
        end
        if (got.heading_err !== exp_cmd.heading_err) begin
          errors = errors + 1;
          $display("%0t: heading_error expected %0d actual %0d",
                   $time, exp_cmd.heading_err, got.heading_err);
        end
        if (got.turn !== exp_cmd.turn) begin
          errors = errors + 1;
          $display("%0t: turn_rate expected %0d actual %0d",
                   $time, exp_cmd.turn, got.turn);
        end
        if (got.fwd !== exp_cmd.fwd) begin
          errors = errors + 1;
          $display("%0t: forward_speed expected %0d actual %0d",
                   $time, exp_cmd.fwd, got.fwd);
        end
      end
    end
  end

  // Send one request and record its command once the transaction completes.
  task automatic send_pose(input pose_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.ty, r.tx, r.qw, r.qz, r.py, r.px};
    do @(posedge clk); while (!s_axis_tready);
    pending_cmds.push_back(predict_steering(r));
    sent_count = sent_count + 1;
  endtask

  task automatic send_fields(input logic [23:0] px, input logic [23:0] py,
                             input logic [15:0] qz, input logic [15:0] qw,
                             input logic [23:0] tx, input logic [23:0] ty);
    pose_req_t r;
    r = '{px, py, qz, qw, tx, ty};
    send_pose(r);
  endtask

  // Wait until every command has come back and the pipeline is empty.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller drops the write enable after the last one.
  task automatic write_reg(input cfg_idx_t idx, input longint unsigned val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val[22:0];
    @(posedge clk);
    if (idx == CFG_DIST_TOL || idx == CFG_SLOW_DIST) cfg_reg[idx] = val & 64'h7FFFFF;
    else cfg_reg[idx] = val & 64'h7FFF;
  endtask

  task automatic load_setting(input longint unsigned v0, input longint unsigned v1,
                              input longint unsigned v2, input longint unsigned v3,
                              input longint unsigned v4, input longint unsigned v5,
                              input longint unsigned v6, input longint unsigned v7);
    wait_idle();
    write_reg(CFG_DIST_TOL, v0);
    write_reg(CFG_ANGLE_TOL, v1);
    write_reg(CFG_SLOW_DIST, v2);
    write_reg(CFG_SLOW_ANGLE, v3);
    write_reg(CFG_MAX_FWD, v4);
    write_reg(CFG_MIN_FWD, v5);
    write_reg(CFG_MAX_TURN, v6);
    write_reg(CFG_MIN_TURN, v7);
    cfg_we <= 1'b0;
    setting_count = setting_count + 1;
  endtask

  // Random request: near the goal, on an axis, or anywhere.
  task automatic send_random_pose();
    pose_req_t r;
    int        mode;
    r    = pose_req_t'({$urandom, $urandom, $urandom, $urandom});
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      r.tx = r.px + 24'($signed($urandom_range(0, 131072)) - 65536);
      r.ty = r.py + 24'($signed($urandom_range(0, 131072)) - 65536);
    end else if (mode == 4) begin
      r.ty = r.py;
    end else if (mode == 5) begin
      r.tx = r.px;
    end
    // Quaternion parts mostly inside the unit range.
    if ($urandom_range(0, 3) != 0) begin
      r.qz = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.qw = 16'($signed($urandom_range(0, 32768)) - 16384);
    end
    send_pose(r);
  endtask

  // Corner cases of the geometry under the reset register values.
  task automatic test_directed();
    send_fields(24'h000000, 24'h000000, 16'h0000, 16'h4000, 24'h000000, 24'h000000);
    send_fields(24'h123456, 24'h654321, 16'h0000, 16'h0000, 24'h123456, 24'h654321);
    send_fields(24'h000000, 24'h000000, 16'h0000, 16'h4000, 24'h010000, 24'h000000);
    send_fields(24'h010000, 24'h000000, 16'h0000, 16'h4000, 24'h000000, 24'h000000);
    send_fields(24'h800000, 24'h800000, 16'hC000, 16'h0000, 24'h7FFFFF, 24'h7FFFFF);
    send_fields(24'h7FFFFF, 24'h7FFFFF, 16'h4000, 16'hC000, 24'h800000, 24'h800000);
    send_fields(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000, 24'h800000, 24'h7FFFFF);
    send_fields(24'h000000, 24'h000000, 16'h8000, 16'h7FFF, 24'h000000, 24'h400000);
    send_fields(24'h000000, 24'h000000, 16'h4000, 16'h0000, 24'h000000, 24'hC00000);
    send_fields(24'h000000, 24'h000000, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_fields(24'h000000, 24'h000000, 16'h2D41, 16'h2D41, 24'h000400, 24'h000400);
    send_fields(24'h000000, 24'h000000, 16'h0000, 16'hC000, 24'h000800, 24'h000000);
    send_fields(24'h000000, 24'h000000, 16'h0000, 16'h4000, 24'h000C00, 24'h000010);
    send_fields(24'h000000, 24'h000000, 16'h0000, 16'h4000, 24'h008000, 24'hFFFFF0);
    send_fields(24'h000000, 24'h000000, 16'h0000, 16'h4000, 24'h008000, 24'h000000);
    send_fields(24'h555555, 24'hAAAAAA, 16'h5555, 16'hAAAA, 24'hAAAAAA, 24'h555555);
  endtask

  // Register sweep including zeros, maxima and floors above maxima.
  task automatic test_register_extremes();
    load_setting(0, 0, 0, 0, 0, 0, 0, 0);
    repeat (40) send_random_pose();
    load_setting(23'h7FFFFF, 25736, 23'h7FFFFF, 25736, 32767, 32767, 32767, 32767);
    repeat (40) send_random_pose();
    load_setting(65536, 1000, 131072, 8192, 2000, 3000, 1000, 1500);
    repeat (40) send_random_pose();
    load_setting(655360, 25736, 0, 25736, 32767, 0, 32767, 0);
    repeat (40) send_random_pose();
    load_setting(3277, 0, 23'h7FFFFF, 1, 1, 32767, 32767, 1);
    repeat (40) send_random_pose();
  endtask

  // Long random run over several register settings, with one hard pause in each.
  task automatic test_random_traffic();
    for (int s = 0; s < 6; s++) begin
      load_setting($urandom_range(0, 23'h7FFFFF) >> $urandom_range(0, 16),
                   $urandom_range(0, 25736), $urandom_range(0, 23'h7FFFFF) >> $urandom_range(0, 12),
                   $urandom_range(0, 25736), $urandom_range(0, 32767),
                   $urandom_range(0, 32767) >> $urandom_range(0, 6),
                   $urandom_range(0, 32767), $urandom_range(0, 32767) >> $urandom_range(0, 6));
      no_idle = (s == 2);
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
        if (i == 100) wait_idle();
        send_random_pose();
      end
      no_idle = 1'b0;
    end
    load_setting(3277, 410, 32768, 4096, 1229, 205, 4096, 410);
    repeat (50) send_random_pose();
  endtask

  initial begin
    errors = 0;
    sent_count = 0;
    checked_count = 0;
    setting_count = 0;
    cycles = 0;
    no_idle = 1'b0;
    ready_hold = 0;
    atan_rom = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                 64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
    cfg_reg = '{3277, 410, 32768, 4096, 1229, 205, 4096, 410};
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_addr      <= CFG_DIST_TOL;
    cfg_data      <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_random_traffic();
    wait_idle();

    $display("Sent %0d poses, checked %0d commands over %0d register settings.",
             sent_count, checked_count, setting_count);
    if (errors == 0 && pending_cmds.size() == 0) begin
      $display("go_to_point_steering verification clean");
    end else begin
      $display("go_to_point_steering verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/gts_pkg.sv
design/gts_cordic_cell.sv
design/gts_div_cell.sv
design/go_to_point_steering.sv
design/go_to_point_steering_chk.sv
tb/sv/tb_go_to_point_steering.sv
